// ===== rtl/assert_macros.svh =====
// assertion macros shared by the checker files
// no dependencies; included by the checker that binds to the controller core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define CHK_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define CHK_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/pidaw_pkg.sv =====
// shared constants, datapath select codes and microcode rom of the pid controller
// no dependencies; used by the controller core and its checker
package pidaw_pkg;

   localparam int DATA_W  = 32;
   localparam int OPND_W  = 33;                 // multiplier operand, holds e - prev
   localparam int PROD_W  = 2 * OPND_W;
   localparam int SUM_W   = 52;                 // three shifted products plus growth
   localparam int COEF_W  = 17;
   localparam int LIMIT_W = 31;
   localparam int FRAC_W  = 16;
   localparam int STEP_W  = 4;
   localparam int CSR_IDX_W = 3;

   localparam logic [COEF_W-1:0] Q_ONE = 17'h10000;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_PROP   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_INTEG  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_DERIV  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_UPPER   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_LOWER   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEG_LIMIT = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_FILTER_COEF = 3'd6;

   localparam logic [DATA_W-1:0]  RST_OUT_UPPER   = 32'h0064_0000;
   localparam logic [DATA_W-1:0]  RST_OUT_LOWER   = 32'hff9c_0000;
   localparam logic [LIMIT_W-1:0] RST_INTEG_LIMIT = 31'h7fff_ffff;
   localparam logic [COEF_W-1:0]  RST_FILTER_COEF = 17'h10000;

   // program steps
   localparam logic [STEP_W-1:0] ST_FILT_NEW  = 4'd0;
   localparam logic [STEP_W-1:0] ST_FILT_OLD  = 4'd1;
   localparam logic [STEP_W-1:0] ST_FILT_SUM  = 4'd2;
   localparam logic [STEP_W-1:0] ST_ERR       = 4'd3;
   localparam logic [STEP_W-1:0] ST_INTEG     = 4'd4;
   localparam logic [STEP_W-1:0] ST_MUL_KI    = 4'd5;
   localparam logic [STEP_W-1:0] ST_MUL_KD    = 4'd6;
   localparam logic [STEP_W-1:0] ST_SUM_LAST  = 4'd7;
   localparam logic [STEP_W-1:0] ST_FINISH    = 4'd8;
   localparam logic [STEP_W-1:0] ST_CLEAR     = 4'd9;

   typedef enum logic [2:0] {
      MA_ERR,
      MA_PREV,
      MA_KP,
      MA_KI,
      MA_KD
   } mul_a_sel_type;

   typedef enum logic [2:0] {
      MB_COEF,
      MB_COMP,
      MB_ERR,
      MB_INTEG,
      MB_DIFF
   } mul_b_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_ADD
   } acc_op_type;

   typedef struct packed {
      mul_a_sel_type     mul_a;
      mul_b_sel_type     mul_b;
      acc_op_type        acc_op;
      logic              acc_shift;    // add product >>> 16 instead of raw product
      logic              latch_err;    // capture filtered error and its difference
      logic              latch_integ;  // update the integral accumulator
      logic              finish;       // saturate, clamp, write state and result
      logic              clear;        // zero the state, result of zero
      logic              jump_clear;   // jump to target when the item is a clear
      logic [STEP_W-1:0] target;
   } ctrl_word_type;

   function automatic ctrl_word_type ctrl_word(
      input mul_a_sel_type     ma,
      input mul_b_sel_type     mb,
      input acc_op_type        aop,
      input logic              shift,
      input logic              le,
      input logic              li,
      input logic              fin,
      input logic              clr,
      input logic              jmp,
      input logic [STEP_W-1:0] tgt
   );
      ctrl_word_type cw;
      cw.mul_a       = ma;
      cw.mul_b       = mb;
      cw.acc_op      = aop;
      cw.acc_shift   = shift;
      cw.latch_err   = le;
      cw.latch_integ = li;
      cw.finish      = fin;
      cw.clear       = clr;
      cw.jump_clear  = jmp;
      cw.target      = tgt;
      return cw;
   endfunction

   // microcode rom
   function automatic ctrl_word_type ucode(input logic [STEP_W-1:0] step);
      ctrl_word_type cw;
      unique case (step)
         ST_FILT_NEW: cw = ctrl_word(MA_ERR,  MB_COEF,  ACC_HOLD, 1'b0,
                                     1'b0, 1'b0, 1'b0, 1'b0, 1'b1, ST_CLEAR);
         ST_FILT_OLD: cw = ctrl_word(MA_PREV, MB_COMP,  ACC_LOAD, 1'b0,
                                     1'b0, 1'b0, 1'b0, 1'b0, 1'b0, ST_FILT_NEW);
         ST_FILT_SUM: cw = ctrl_word(MA_PREV, MB_COMP,  ACC_ADD,  1'b0,
                                     1'b0, 1'b0, 1'b0, 1'b0, 1'b0, ST_FILT_NEW);
         ST_ERR:      cw = ctrl_word(MA_KP,   MB_ERR,   ACC_HOLD, 1'b0,
                                     1'b1, 1'b0, 1'b0, 1'b0, 1'b0, ST_FILT_NEW);
         ST_INTEG:    cw = ctrl_word(MA_KP,   MB_ERR,   ACC_HOLD, 1'b0,
                                     1'b0, 1'b1, 1'b0, 1'b0, 1'b0, ST_FILT_NEW);
         ST_MUL_KI:   cw = ctrl_word(MA_KI,   MB_INTEG, ACC_LOAD, 1'b1,
                                     1'b0, 1'b0, 1'b0, 1'b0, 1'b0, ST_FILT_NEW);
         ST_MUL_KD:   cw = ctrl_word(MA_KD,   MB_DIFF,  ACC_ADD,  1'b1,
                                     1'b0, 1'b0, 1'b0, 1'b0, 1'b0, ST_FILT_NEW);
         ST_SUM_LAST: cw = ctrl_word(MA_KD,   MB_DIFF,  ACC_ADD,  1'b1,
                                     1'b0, 1'b0, 1'b0, 1'b0, 1'b0, ST_FILT_NEW);
         ST_FINISH:   cw = ctrl_word(MA_KD,   MB_DIFF,  ACC_HOLD, 1'b0,
                                     1'b0, 1'b0, 1'b1, 1'b0, 1'b0, ST_FILT_NEW);
         default:     cw = ctrl_word(MA_ERR,  MB_COEF,  ACC_HOLD, 1'b0,
                                     1'b0, 1'b0, 1'b0, 1'b1, 1'b0, ST_FILT_NEW);
      endcase
      return cw;
   endfunction

endpackage

// ===== rtl/pid_antiwindup_controller_core.sv =====
// positional pid step with conditional-integration anti-windup, q16.16 fixed point
// a control item runs the steps from filt_new to finish, a clear item jumps from filt_new to clear
// one item is in flight at a time, and a stalled result holds it, since the shared 33x33 multiplier
// is walked by the microcode program through the filter, gain and sum steps one by one
// synchronous active-high reset: gains to zero, limits and filter weight to their
// defaults, filter, integral and last raw output state to zero, no result pending
module pid_antiwindup_controller_core
   import pidaw_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   // input item channel
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_op,
   input  logic signed [DATA_W-1:0]    req_error_in,
   // result item channel
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [DATA_W-1:0]    rsp_drive_out,
   output logic                        rsp_limited,
   // configuration write port
   input  logic                        csr_we,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [DATA_W-1:0]           csr_wdata
);

   // configuration registers
   logic signed [DATA_W-1:0] kp_ff, ki_ff, kd_ff, upper_ff, lower_ff;
   logic [LIMIT_W-1:0]       limit_ff;
   logic [COEF_W-1:0]        coef_ff;

   // sequencer
   logic                     busy_ff;
   logic [STEP_W-1:0]        step_ff;
   ctrl_word_type            cw;

   // item and controller state
   logic                     op_ff;
   logic signed [DATA_W-1:0] err_ff;
   logic signed [DATA_W-1:0] prev_ff;       // previous filtered error
   logic signed [DATA_W-1:0] integ_ff;      // integral accumulator
   logic signed [DATA_W-1:0] last_raw_ff;   // last unclamped output

   // datapath registers
   logic signed [DATA_W-1:0] e_ff, e_in;
   logic signed [OPND_W-1:0] d_ff, d_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in, addend;

   logic signed [DATA_W-1:0]  rsp_drive_ff;
   logic                      rsp_limited_ff, rsp_valid_ff;

   logic                      req_fire, out_free, advance_done;
   logic [COEF_W-1:0]         coef_eff, coef_comp;
   logic signed [OPND_W-1:0]  mul_a, mul_b;

   logic                      outside, integrate;
   logic signed [OPND_W-1:0]  isum, ilim;
   logic signed [DATA_W-1:0]  integ_in;

   logic                      ovf;
   logic signed [DATA_W-1:0]  raw_in, clip_hi, drive_in;

   assign req_ready     = !busy_ff;
   assign req_fire      = req_valid && req_ready;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_drive_out = rsp_drive_ff;
   assign rsp_limited   = rsp_limited_ff;

   // result register frees up this cycle if empty or being taken
   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign cw           = ucode(step_ff);
   assign advance_done = busy_ff && (cw.finish || cw.clear) && out_free;

   // filter weight above one acts as one
   assign coef_eff  = coef_ff[COEF_W-1] ? Q_ONE : coef_ff;
   assign coef_comp = Q_ONE - coef_eff;

   // shared multiplier operand selection
   always_comb begin
      case (cw.mul_a)
         MA_ERR:  mul_a = OPND_W'(err_ff);
         MA_PREV: mul_a = OPND_W'(prev_ff);
         MA_KP:   mul_a = OPND_W'(kp_ff);
         MA_KI:   mul_a = OPND_W'(ki_ff);
         MA_KD:   mul_a = OPND_W'(kd_ff);
         default: mul_a = '0;
      endcase
      case (cw.mul_b)
         MB_COEF:  mul_b = $signed({{(OPND_W-COEF_W){1'b0}}, coef_eff});
         MB_COMP:  mul_b = $signed({{(OPND_W-COEF_W){1'b0}}, coef_comp});
         MB_ERR:   mul_b = OPND_W'(e_ff);
         MB_INTEG: mul_b = OPND_W'(integ_ff);
         MB_DIFF:  mul_b = d_ff;
         default:  mul_b = '0;
      endcase
   end

   assign prod_in = mul_a * mul_b;

   // accumulator: filter products go in whole, gain products floor-shifted by 16
   assign addend = cw.acc_shift ? SUM_W'($signed(prod_ff[PROD_W-1:FRAC_W]))
                                : $signed(prod_ff[SUM_W-1:0]);
   always_comb begin
      case (cw.acc_op)
         ACC_LOAD: sum_in = addend;
         ACC_ADD:  sum_in = sum_ff + addend;
         default:  sum_in = sum_ff;
      endcase
   end

   // filtered error is a convex mix of two 32-bit values, so bits 47:16 hold it
   assign e_in = $signed(sum_ff[DATA_W+FRAC_W-1:FRAC_W]);
   assign d_in = OPND_W'(e_in) - OPND_W'(prev_ff);

   // conditional integration: when the last raw output sat outside the limits,
   // only integrate an error of strictly opposite sign
   assign outside   = (last_raw_ff > upper_ff) || (last_raw_ff < lower_ff);
   assign integrate = !outside
                      || (last_raw_ff > 0 && e_ff < 0)
                      || (last_raw_ff < 0 && e_ff > 0);
   assign isum      = OPND_W'(integ_ff) + (integrate ? OPND_W'(e_ff) : OPND_W'(0));
   assign ilim      = $signed({{(OPND_W-LIMIT_W){1'b0}}, limit_ff});
   always_comb begin
      if (isum > ilim) begin
         integ_in = DATA_W'(ilim);
      end else if (isum < -ilim) begin
         integ_in = DATA_W'(-ilim);
      end else begin
         integ_in = DATA_W'(isum);
      end
   end

   // saturate the gain sum to 32 bits, then clamp upper first and lower last
   assign ovf    = !(&sum_ff[SUM_W-1:DATA_W-1]) && (|sum_ff[SUM_W-1:DATA_W-1]);
   assign raw_in = ovf ? (sum_ff[SUM_W-1] ? $signed({1'b1, {(DATA_W-1){1'b0}}})
                                          : $signed({1'b0, {(DATA_W-1){1'b1}}}))
                       : $signed(sum_ff[DATA_W-1:0]);
   assign clip_hi  = (raw_in > upper_ff) ? upper_ff : raw_in;
   assign drive_in = (clip_hi < lower_ff) ? lower_ff : clip_hi;

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff          <= '0;
         ki_ff          <= '0;
         kd_ff          <= '0;
         upper_ff       <= RST_OUT_UPPER;
         lower_ff       <= RST_OUT_LOWER;
         limit_ff       <= RST_INTEG_LIMIT;
         coef_ff        <= RST_FILTER_COEF;
         busy_ff        <= 1'b0;
         step_ff        <= ST_FILT_NEW;
         prev_ff        <= '0;
         integ_ff       <= '0;
         last_raw_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         // configuration writes, unknown index ignored
         if (csr_we) begin
            unique case (csr_index)
               CSR_GAIN_PROP:   kp_ff    <= csr_wdata;
               CSR_GAIN_INTEG:  ki_ff    <= csr_wdata;
               CSR_GAIN_DERIV:  kd_ff    <= csr_wdata;
               CSR_OUT_UPPER:   upper_ff <= csr_wdata;
               CSR_OUT_LOWER:   lower_ff <= csr_wdata;
               CSR_INTEG_LIMIT: limit_ff <= csr_wdata[LIMIT_W-1:0];
               CSR_FILTER_COEF: coef_ff  <= csr_wdata[COEF_W-1:0];
               default: ;
            endcase
         end

         // step counter with the clear jump
         if (!busy_ff) begin
            if (req_fire) begin
               busy_ff <= 1'b1;
               step_ff <= ST_FILT_NEW;
            end
         end else if (cw.jump_clear && op_ff) begin
            step_ff <= cw.target;
         end else if (cw.finish || cw.clear) begin
            if (out_free) begin
               busy_ff <= 1'b0;
            end
         end else begin
            step_ff <= step_ff + 1'b1;
         end

         // state updates: the integral at the integ step, the rest (or all, for a clear) at the end of an item
         if (advance_done && cw.clear) begin
            prev_ff     <= '0;
            integ_ff    <= '0;
            last_raw_ff <= '0;
         end else if (advance_done) begin
            prev_ff     <= e_ff;
            last_raw_ff <= raw_in;
         end else if (busy_ff && cw.latch_integ) begin
            integ_ff    <= integ_in;
         end

         // result register
         if (advance_done) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload and datapath registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff  <= req_op;
         err_ff <= req_error_in;
      end
      if (busy_ff) begin
         prod_ff <= prod_in;
         sum_ff  <= sum_in;
      end
      if (busy_ff && cw.latch_err) begin
         e_ff <= e_in;
         d_ff <= d_in;
      end
      if (advance_done) begin
         rsp_drive_ff   <= cw.clear ? '0 : drive_in;
         rsp_limited_ff <= cw.clear ? 1'b0 : (drive_in != raw_in);
      end
   end

endmodule

// ===== rtl/pidaw_checker.sv =====
// port-level checker for the pid controller core, attached by the bind below
// depends on pidaw_pkg and assert_macros.svh
`include "assert_macros.svh"

module pidaw_checker
   import pidaw_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic signed [DATA_W-1:0] rsp_drive_out,
   input logic                     rsp_limited,
   input logic                     csr_we,
   input logic [CSR_IDX_W-1:0]     csr_index,
   input logic [DATA_W-1:0]        csr_wdata
);

   logic [1:0]               pending_ff;
   logic signed [DATA_W-1:0] upper_ff, lower_ff;
   logic                     in_fire, out_fire;

   assign in_fire    = req_valid && req_ready;
   assign out_fire   = rsp_valid && rsp_ready;

   // items inside the block and shadow copies of the output limits
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         upper_ff   <= RST_OUT_UPPER;
         lower_ff   <= RST_OUT_LOWER;
      end else begin
         pending_ff <= pending_ff + {1'b0, in_fire} - {1'b0, out_fire};
         if (csr_we && csr_index == CSR_OUT_UPPER) begin
            upper_ff <= csr_wdata;
         end
         if (csr_we && csr_index == CSR_OUT_LOWER) begin
            lower_ff <= csr_wdata;
         end
      end
   end

   `CHK_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_drive_out) && $stable(rsp_limited), "result dropped while stalled")
   `CHK_IMPLY(a_no_phantom, clock, reset, rsp_valid, pending_ff != 2'd0,
      "result with no item outstanding")
   `CHK_IMPLY(a_depth, clock, reset, 1'b1, pending_ff != 2'd3,
      "more items outstanding than the block can hold")
   `CHK_IMPLY(a_limited_on_bound, clock, reset, rsp_valid && rsp_limited,
      rsp_drive_out == upper_ff || rsp_drive_out == lower_ff, "limited result off both bounds")
   `CHK_NEXT(a_one_in_flight, clock, reset, in_fire, !req_ready,
      "second item accepted while one is in flight")

endmodule

bind pid_antiwindup_controller_core pidaw_checker u_pidaw_checker (.*);
